[rtl/core/mkgs_pkg.sv]
// ----------------------------------------------------------------------------
// mkgs_pkg
// Types and constants shared by the keypad gesture scanner modules.
// ----------------------------------------------------------------------------
package mkgs_pkg;

    localparam int LEVELS_W    = 4;
    localparam int KEY_NUM_W   = 5;
    localparam int GESTURE_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [3:0] RUN_MAX   = 4'd15;
    localparam logic [7:0] TICKS_MAX = 8'd255;
    localparam logic [2:0] COUNT_MAX = 3'd7;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLICK_GAP  = 2'd2;

    localparam logic [3:0] DEBOUNCE_RST   = 4'd3;
    localparam logic [7:0] LONG_PRESS_RST = 8'd30;
    localparam logic [7:0] CLICK_GAP_RST  = 8'd15;

    // gesture codes
    localparam logic [GESTURE_W-1:0] GEST_SINGLE = 2'd0;
    localparam logic [GESTURE_W-1:0] GEST_DOUBLE = 2'd1;
    localparam logic [GESTURE_W-1:0] GEST_LONG   = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2
    } phase_t;

    typedef struct packed {
        logic       stable;
        logic [3:0] run;
        phase_t     phase;
        logic [7:0] ticks;
        logic [2:0] count;
    } key_state_t;

    typedef struct packed {
        logic [3:0] debounce;
        logic [7:0] long_press;
        logic [7:0] click_gap;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic [GESTURE_W-1:0] gesture;
    } key_event_t;

    localparam key_state_t KEY_RST = '{
        stable: 1'b1,
        run:    4'd0,
        phase:  PH_IDLE,
        ticks:  8'd0,
        count:  3'd0
    };

endpackage

[rtl/core/mkgs_key_cell.sv]
// ----------------------------------------------------------------------------
// mkgs_key_cell
// Debounce and gesture step for one key: next state and event, no storage.
// ----------------------------------------------------------------------------
module mkgs_key_cell
    import mkgs_pkg::*;
(
    input  key_state_t cur,
    input  logic       sample,
    input  cfg_t       cfg,
    output key_state_t nxt,
    output key_event_t ev
);

    phase_t     ph;
    logic [7:0] ticks_inc;
    logic [3:0] run_inc;
    logic       stable_new;
    logic [3:0] run_new;
    logic       long_hit;
    logic       gap_hit;

    // unused phase code behaves as idle
    assign ph = (cur.phase == PH_PRESSED || cur.phase == PH_RELEASED) ? cur.phase : PH_IDLE;

    assign ticks_inc = (ph != PH_IDLE && cur.ticks < TICKS_MAX) ? cur.ticks + 8'd1 : cur.ticks;
    assign run_inc   = (cur.run < RUN_MAX) ? cur.run + 4'd1 : cur.run;

    always_comb
    begin
        stable_new = cur.stable;
        run_new    = 4'd0;
        if (cur.stable != sample)
        begin
            if (run_inc >= cfg.debounce)
            begin
                stable_new = sample;
            end
            else
            begin
                run_new = run_inc;
            end
        end
    end

    assign long_hit = (ticks_inc >= cfg.long_press);
    assign gap_hit  = (ticks_inc >= cfg.click_gap);

    // next state
    always_comb
    begin
        nxt        = cur;
        nxt.stable = stable_new;
        nxt.run    = run_new;
        nxt.ticks  = ticks_inc;
        nxt.phase  = ph;
        unique case (ph)
            PH_IDLE:
            begin
                if (!stable_new)
                begin
                    nxt.ticks = 8'd0;
                    nxt.count = 3'd1;
                    nxt.phase = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                if (stable_new)
                begin
                    if (long_hit)
                    begin
                        nxt.phase = PH_IDLE;
                    end
                    else
                    begin
                        nxt.ticks = 8'd0;
                        nxt.phase = PH_RELEASED;
                    end
                end
                else if (long_hit)
                begin
                    nxt.count = 3'd0;
                end
            end
            PH_RELEASED:
            begin
                if (gap_hit)
                begin
                    nxt.phase = PH_IDLE;
                end
                else if (!stable_new)
                begin
                    if (cur.count < COUNT_MAX)
                    begin
                        nxt.count = cur.count + 3'd1;
                    end
                    nxt.ticks = 8'd0;
                    nxt.phase = PH_PRESSED;
                end
            end
            default:
            begin
                nxt.phase = PH_IDLE;
            end
        endcase
    end

    // event
    always_comb
    begin
        ev.valid   = 1'b0;
        ev.gesture = GEST_SINGLE;
        unique case (ph)
            PH_IDLE:
            begin
                ev.valid = 1'b0;
            end
            PH_PRESSED:
            begin
                if (stable_new && long_hit)
                begin
                    ev.valid   = 1'b1;
                    ev.gesture = GEST_LONG;
                end
            end
            PH_RELEASED:
            begin
                if (gap_hit && cur.count == 3'd1)
                begin
                    ev.valid   = 1'b1;
                    ev.gesture = GEST_SINGLE;
                end
                else if (gap_hit && cur.count == 3'd2)
                begin
                    ev.valid   = 1'b1;
                    ev.gesture = GEST_DOUBLE;
                end
            end
            default:
            begin
                ev.valid = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/matrix_keypad_gesture_scanner.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_gesture_scanner
// Keypad scanner with debounce and click, double-click, long-press detection.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one transaction per scan tick, carrying column_levels of the
//                 row currently driven low. Rows rotate from row 0.
//   out channel : one transaction per event (key_number, gesture); last marks
//                 the final event of a tick. A tick with no event sends nothing.
//   cfg port    : cfg_write/cfg_index/cfg_data, written while idle only.
// Path: a tick's events pass through the input register, then the event
//   register of the row, on their way to the outputs.
// Throughput: one tick per cycle while no tick yields more than one event
//   and the output does not stall; a tick with more events holds the event
//   register till its last leaves, one per cycle, by the single output port.
// Reset: all keys released and idle, scan row 0, registers at their defaults.
// Stall: a stalled output holds its transaction; one further tick is still
//   taken into the input register, after which in_stall rises.
// ----------------------------------------------------------------------------
module matrix_keypad_gesture_scanner
    import mkgs_pkg::*;
#(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // scan ticks
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [LEVELS_W-1:0]    column_levels,
    // events
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [KEY_NUM_W-1:0]   key_number,
    output logic [GESTURE_W-1:0]   gesture,
    output logic                   last,
    // configuration
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    // configuration registers
    cfg_t cfg_reg;

    // per key state, one row of keys per entry
    key_state_t state_reg [ROWS][COLUMNS];
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    // input register
    logic                in_full_reg;
    logic                in_full_next;
    logic [LEVELS_W-1:0] levels_reg;

    // event register: one slot per column of the row just processed
    logic [COLUMNS-1:0]   ev_mask_reg;
    logic [COLUMNS-1:0]   ev_mask_next;
    logic [GESTURE_W-1:0] ev_gest_reg [COLUMNS];
    logic [RW-1:0]        ev_row_reg;

    key_state_t         key_next [COLUMNS];
    key_event_t         key_ev   [COLUMNS];
    logic [COLUMNS-1:0] ev_hit;

    logic [COLUMNS-1:0] low_bit;
    logic [CW-1:0]      sel;
    logic               out_fire;
    logic               in_fire;
    logic               slot_free;
    logic               advance;

    // ------------------------------------------------------------------
    // Key cells for the current row
    // ------------------------------------------------------------------
    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_col
        logic sample;
        if (c < LEVELS_W)
        begin : g_in
            assign sample = levels_reg[c];
        end
        else
        begin : g_out
            // columns beyond the input width read as pressed
            assign sample = 1'b0;
        end

        mkgs_key_cell u_cell (
            .cur    (state_reg[row_reg][c]),
            .sample (sample),
            .cfg    (cfg_reg),
            .nxt    (key_next[c]),
            .ev     (key_ev[c])
        );

        assign ev_hit[c] = key_ev[c].valid;
    end

    // ------------------------------------------------------------------
    // Output selection: lowest pending column goes first
    // ------------------------------------------------------------------
    assign low_bit = ev_mask_reg & (~ev_mask_reg + COLUMNS'(1));

    always_comb
    begin
        sel = '0;
        for (int c = COLUMNS - 1; c >= 0; c--)
        begin
            if (ev_mask_reg[c])
            begin
                sel = CW'(c);
            end
        end
    end

    assign out_valid  = |ev_mask_reg;
    assign gesture    = ev_gest_reg[sel];
    assign last       = ((ev_mask_reg & ~low_bit) == '0);
    assign key_number = KEY_NUM_W'(int'(ev_row_reg) * COLUMNS + int'(sel) + 1);

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign out_fire  = out_valid && !out_stall;
    assign slot_free = !out_valid || (out_fire && last);
    assign advance   = in_full_reg && slot_free;
    assign in_stall  = in_full_reg && !slot_free;
    assign in_fire   = in_valid && !in_stall;

    assign row_next     = (row_reg >= ROW_LAST) ? '0 : row_reg + RW'(1);
    assign in_full_next = in_fire ? 1'b1 : (advance ? 1'b0 : in_full_reg);

    always_comb
    begin
        ev_mask_next = ev_mask_reg;
        if (advance)
        begin
            ev_mask_next = ev_hit;
        end
        else if (out_fire)
        begin
            ev_mask_next = ev_mask_reg & ~low_bit;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce   <= DEBOUNCE_RST;
            cfg_reg.long_press <= LONG_PRESS_RST;
            cfg_reg.click_gap  <= CLICK_GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   cfg_reg.debounce   <= cfg_data[3:0];
                REG_LONG_PRESS: cfg_reg.long_press <= cfg_data;
                REG_CLICK_GAP:  cfg_reg.click_gap  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLUMNS; c++)
                begin
                    state_reg[r][c] <= KEY_RST;
                end
            end
            row_reg     <= '0;
            in_full_reg <= 1'b0;
            ev_mask_reg <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            ev_mask_reg <= ev_mask_next;
            if (advance)
            begin
                for (int c = 0; c < COLUMNS; c++)
                begin
                    state_reg[row_reg][c] <= key_next[c];
                end
                row_reg <= row_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            levels_reg <= column_levels;
        end
        if (advance)
        begin
            ev_row_reg <= row_reg;
            for (int c = 0; c < COLUMNS; c++)
            begin
                ev_gest_reg[c] <= key_ev[c].gesture;
            end
        end
    end

endmodule

[rtl/core/mkgs_checker.sv]
// ----------------------------------------------------------------------------
// mkgs_checker
// Port-level checks on the handshakes of the keypad gesture scanner.
// ----------------------------------------------------------------------------
module mkgs_checker
    import mkgs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [KEY_NUM_W-1:0]   key_number,
    input logic [GESTURE_W-1:0]   gesture,
    input logic                   last
);

    // stalled event holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(key_number)
            && $stable(gesture) && $stable(last))
        else $error("event changed while stalled");

    // only legal gesture codes leave the block
    a_gesture_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gesture == GEST_SINGLE || gesture == GEST_DOUBLE
            || gesture == GEST_LONG))
        else $error("illegal gesture code");

    // a tick's events go out without a gap until the one marked last
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("event burst broken before last");

    // within a burst, no key is reported twice in a row
    a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> key_number != $past(key_number))
        else $error("event repeated within a burst");

    // input is held off only while an event waits at the output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no event waiting");

endmodule

bind matrix_keypad_gesture_scanner mkgs_checker u_mkgs_checker (.*);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad gesture scanner: a scoreboard class
// predicts every event from the scan ticks it sees accepted, and plain tasks
// drive ticks, register writes and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mkgs_pkg::*;

    localparam int SCAN_ROWS = 4;
    localparam int KEY_COLS = 4;
    localparam int KEY_COUNT = SCAN_ROWS * KEY_COLS;

    // index with no register behind it; writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam int STALL_LIMIT = 2000;      // cycles with no transaction at all
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES = 10;        // covers the input and event registers plus a full row
    localparam int MAX_REPORTS = 60;

    // one visit per row: column 0 double, 1 single, 2 long, 3 three presses
    localparam logic [LEVELS_W-1:0] DIRECTED_VISITS [6] =
        '{4'b0000, 4'b1011, 4'b0010, 4'b1011, 4'b0111, 4'b1111};

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

    typedef struct packed {
        logic [KEY_NUM_W-1:0] key;
        logic [GESTURE_W-1:0] gest;
        logic                 last;
    } gesture_event_t;

    // ------------------------------------------------------------------------
    // Scoreboard: per-key debounce and gesture machines, the register copy and
    // the queue of events still owed by the block.
    // ------------------------------------------------------------------------
    class keypad_scoreboard;
        key_state_t     keys [KEY_COUNT];
        cfg_t           cfg;
        int             scan_row;
        gesture_event_t events_due [$];
        int             ticks_noted;
        int             predicted;
        int             checked;
        int             errors;
        int             gesture_seen [3];

        function new();
            foreach (keys[k])
                keys[k] = KEY_RST;
            cfg = '{debounce: DEBOUNCE_RST, long_press: LONG_PRESS_RST,
                    click_gap: CLICK_GAP_RST};
            scan_row = 0;
            ticks_noted = 0;
            predicted = 0;
            checked = 0;
            errors = 0;
            foreach (gesture_seen[g])
                gesture_seen[g] = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx,
                                   logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEBOUNCE:   cfg.debounce = data[3:0];
                REG_LONG_PRESS: cfg.long_press = data;
                REG_CLICK_GAP:  cfg.click_gap = data;
                default: ;
            endcase
        endfunction

        // advance one key by one sample
        function key_event_t step_key(int k, logic sample);
            key_state_t s;
            key_event_t ev;
            phase_t     ph;
            s = keys[k];
            ev = '{valid: 1'b0, gesture: GEST_SINGLE};
            ph = s.phase;
            if (ph != PH_PRESSED && ph != PH_RELEASED)
                ph = PH_IDLE;

            if (ph != PH_IDLE && s.ticks != TICKS_MAX)
                s.ticks = s.ticks + 8'd1;

            if (s.stable != sample)
            begin
                if (s.run != RUN_MAX)
                    s.run = s.run + 4'd1;
                if (s.run >= cfg.debounce)
                begin
                    s.stable = sample;
                    s.run = 4'd0;
                end
            end
            else
                s.run = 4'd0;

            case (ph)
                PH_IDLE:
                begin
                    if (!s.stable)
                    begin
                        s.ticks = 8'd0;
                        s.count = 3'd1;
                        ph = PH_PRESSED;
                    end
                end
                PH_PRESSED:
                begin
                    if (s.stable)
                    begin
                        if (s.ticks >= cfg.long_press)
                        begin
                            ev = '{valid: 1'b1, gesture: GEST_LONG};
                            ph = PH_IDLE;
                        end
                        else
                        begin
                            s.ticks = 8'd0;
                            ph = PH_RELEASED;
                        end
                    end
                    else if (s.ticks >= cfg.long_press)
                        s.count = 3'd0;
                end
                default:
                begin
                    if (s.ticks >= cfg.click_gap)
                    begin
                        ph = PH_IDLE;
                        if (s.count == 3'd1)
                            ev = '{valid: 1'b1, gesture: GEST_SINGLE};
                        else if (s.count == 3'd2)
                            ev = '{valid: 1'b1, gesture: GEST_DOUBLE};
                    end
                    else if (!s.stable)
                    begin
                        if (s.count != COUNT_MAX)
                            s.count = s.count + 3'd1;
                        s.ticks = 8'd0;
                        ph = PH_PRESSED;
                    end
                end
            endcase
            s.phase = ph;
            keys[k] = s;
            return ev;
        endfunction

        // accepted scan tick: predict its events in column order
        function void note_tick(logic [LEVELS_W-1:0] levels);
            gesture_event_t batch [KEY_COLS];
            key_event_t     ev;
            int             n;
            int             k;
            n = 0;
            for (int c = 0; c < KEY_COLS; c++)
            begin
                k = scan_row * KEY_COLS + c;
                ev = step_key(k, levels[c]);
                if (ev.valid)
                begin
                    batch[n] = '{key: KEY_NUM_W'(k + 1), gest: ev.gesture, last: 1'b0};
                    gesture_seen[ev.gesture]++;
                    n++;
                end
            end
            if (n > 0)
                batch[n - 1].last = 1'b1;
            for (int i = 0; i < n; i++)
                events_due.push_back(batch[i]);
            predicted += n;
            ticks_noted++;
            scan_row = (scan_row + 1) % SCAN_ROWS;
        endfunction

        function void report(string field, int expd, int act);
            if (errors < MAX_REPORTS)
                $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, expd, act);
            errors++;
        endfunction

        // accepted event transaction: compare with the oldest prediction
        function void check_event(logic [KEY_NUM_W-1:0] key,
                                  logic [GESTURE_W-1:0] gest, logic last_flag);
            gesture_event_t want;
            if (events_due.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0d ns: unexpected event, expected none, actual key %0d gesture %0d",
                             $time, key, gest);
                errors++;
                return;
            end
            want = events_due.pop_front();
            checked++;
            if (key !== want.key)
                report("key_number", want.key, key);
            if (gest !== want.gest)
                report("gesture", want.gest, gest);
            if (last_flag !== want.last)
                report("last", want.last, last_flag);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its ports; every input known from time zero
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [LEVELS_W-1:0]    column_levels = '1;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [KEY_NUM_W-1:0]   key_number;
    logic [GESTURE_W-1:0]   gesture;
    logic                   last;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    matrix_keypad_gesture_scanner #(
        .ROWS    (SCAN_ROWS),
        .COLUMNS (KEY_COLS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .column_levels (column_levels),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .key_number    (key_number),
        .gesture       (gesture),
        .last          (last),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    keypad_scoreboard     sb;
    logic [KEY_COUNT-1:0] held_keys;        // stimulus view of the keypad, 0 = held
    int                   burst_left = 0;   // ticks left in the current sender burst
    int                   hold_off_req = 0; // receiver hold-off request, in cycles
    int                   settings_used = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: back-pressure switches style at regular intervals; a hold-off
    // request overrides it and is counted down here, in this process.
    // ------------------------------------------------------------------------
    initial
    begin
        stall_mode_t mode;
        int          cyc;
        int          hold_left;
        mode = STALL_NONE;
        cyc = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req > 0)
            begin
                hold_left = hold_off_req;
                hold_off_req = 0;
            end
            if (cyc % 50 == 0)
                mode = stall_mode_t'($urandom_range(0, 3));
            cyc++;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
                    default:     out_stall <= ((cyc % 7) < 3);
                endcase
            end
        end
    end

    // event monitor: values read at the edge are the ones before it
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_event(key_number, gesture, last);
    end

    // watchdog: gives up after a long stretch with no transaction anywhere
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transaction for %0d cycles, %0d events still owed",
                 STALL_LIMIT, sb.events_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender tasks; all of them start and finish on a falling edge
    // ------------------------------------------------------------------------

    // One scan tick transaction. Bursts of random length with random gaps;
    // some bursts run long with no gap at all. Valid is only dropped when a
    // real gap follows, so it is never lowered and raised in one step.
    task automatic send_tick(input logic [LEVELS_W-1:0] lv);
        int gap;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(40, 80);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(0, 12);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        column_levels <= lv;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_tick(lv);
        burst_left--;
        @(negedge clk);
    endtask

    // Sender pause: nothing offered until every owed event has come out,
    // then a few more cycles in case the last tick yields no event.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.events_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    // one register write; cfg_write is left high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.set_register(idx, data);
        @(negedge clk);
    endtask

    // new settings, only once the block has gone quiet
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] debounce,
                                  input logic [CFG_DATA_W-1:0] long_press,
                                  input logic [CFG_DATA_W-1:0] click_gap);
        drain();
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_LONG_PRESS, long_press);
        write_reg(REG_CLICK_GAP, click_gap);
        cfg_write <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // Random keypad use: keys in the row being scanned are pressed or let go
    // with the given chance per visit, contacts bounce now and then, and a
    // few ticks carry plain noise. With an event goal the stretch may run on,
    // up to twice its length, until that many events have been predicted.
    task automatic random_ticks(input int n_ticks, input int toggle_pct,
                                input int bounce_pct, input int event_goal);
        int                  sent;
        int                  r;
        int                  b;
        logic [LEVELS_W-1:0] lv;
        sent = 0;
        while (sent < n_ticks || (sb.predicted < event_goal && sent < 2 * n_ticks))
        begin
            r = sb.scan_row;
            for (int c = 0; c < KEY_COLS; c++)
                if ($urandom_range(0, 99) < toggle_pct)
                    held_keys[r * KEY_COLS + c] = ~held_keys[r * KEY_COLS + c];
            lv = held_keys[r * KEY_COLS +: KEY_COLS];
            if ($urandom_range(0, 99) < bounce_pct)
            begin
                b = $urandom_range(0, KEY_COLS - 1);
                lv[b] = ~lv[b];
            end
            else if ($urandom_range(0, 49) == 0)
                lv = LEVELS_W'($urandom_range(0, 15));
            if ($urandom_range(0, 59) == 0)
                drain();
            send_tick(lv);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int random_base;
        sb = new();
        held_keys = '1;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // a few ticks on the reset settings
        repeat (8) send_tick(LEVELS_W'($urandom_range(0, 15)));

        // Directed: fast settings so that within six visits per row every
        // column shows its own gesture: single, double, long, and a third
        // press that must stay silent later on. The receiver holds off
        // meanwhile, so events pile up and the block stalls its input.
        apply_settings(8'd1, 8'd3, 8'd2);
        hold_off_req = HOLD_OFF_CYCLES;
        foreach (DIRECTED_VISITS[v])
            repeat (SCAN_ROWS) send_tick(DIRECTED_VISITS[v]);

        random_base = sb.predicted;

        // instant debounce
        apply_settings(8'd0, 8'd4, 8'd3);
        random_ticks(12, 30, 5, 0);

        // bounces shorter than the debounce run must be filtered
        apply_settings(8'd2, 8'd6, 8'd4);
        random_ticks(12, 25, 10, 0);

        // longest debounce; top nibble of the write data must be dropped
        apply_settings(8'hFF, 8'd1, 8'd1);
        random_ticks(16, 6, 0, 0);

        // zero thresholds: every release is long, every gap is over at once
        apply_settings(8'd1, 8'd0, 8'd0);
        random_ticks(12, 30, 5, 0);

        // ordinary use, run on a little if few events have come out
        apply_settings(8'd1, 8'd2, 8'd2);
        random_ticks(16, 40, 5, random_base + 8);

        drain();

        $display("Covered %0d scan ticks over %0d register settings; %0d events checked",
                 sb.ticks_noted, settings_used, sb.checked);
        $display("Gestures seen: %0d single, %0d double, %0d long press",
                 sb.gesture_seen[GEST_SINGLE], sb.gesture_seen[GEST_DOUBLE],
                 sb.gesture_seen[GEST_LONG]);
        if (sb.errors == 0 && sb.events_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
